/* hw/rtl/p2r_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2r_pkg
// shared constants, arctangent table, gain constant and the vector type that
// moves between the rotation cells of the polar to rectangular core
// ----------------------------------------------------------------------------
package p2r_pkg;

   // default configuration
   localparam int P2R_MAG_BITS = 16;
   localparam int P2R_STAGES   = 16;

   // datapath: signed x/y words (60 magnitude bits plus sign and headroom)
   localparam int P2R_DW = 62;
   // angle word: 2^32 is a full turn
   localparam int P2R_ZW = 32;

   // atan(2^-i) in 32-bit binary angle units, truncated
   localparam logic [P2R_ZW-1:0] P2R_ATAN [32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
   };

   // one beat in flight through the rotation chain
   typedef struct packed {
      logic                     valid;
      logic signed [P2R_DW-1:0] x;
      logic signed [P2R_DW-1:0] y;
      logic [P2R_ZW-1:0]        z;
   } p2r_vec_type;

   // gain compensation in unsigned Q32, evaluated at elaboration only
   function automatic logic [31:0] p2r_gain_comp(input int stages);
      logic [63:0] p;
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bitv;
      logic [63:0] num;
      logic [64:0] rem;
      logic [63:0] quo;
      int          cnt;
      cnt = (stages > 32) ? 32 : stages;
      // product of (1 + 4^-i) in Q62
      p = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (i < cnt) begin
            p = p + (p >> (2 * i));
         end
      end
      // integer square root
      n    = p;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (bitv > n) begin
            bitv = bitv >> 2;
         end
      end
      for (int k = 0; k < 32; k++) begin
         if (bitv != 0) begin
            if (n >= res + bitv) begin
               n   = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      // 2^63 / root by restoring long division
      num = 64'd1 << 63;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, res}) begin
            rem    = rem - {1'b0, res};
            quo[b] = 1'b1;
         end
      end
      return quo[31:0];
   endfunction

endpackage

/* hw/rtl/p2r_prescale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2r_prescale
// scales the magnitude by the gain compensation and folds the angle into
// [-pi/2, pi/2); two register stages, the first holds the product
// ----------------------------------------------------------------------------
module p2r_prescale
   import p2r_pkg::*;
#(
   parameter int MAG_BITS = P2R_MAG_BITS,
   parameter int STAGES   = P2R_STAGES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [MAG_BITS-1:0] in_mag,
   input  logic [15:0]         in_phase,
   output p2r_vec_type         out_vec
);

   localparam int          FRAC = 60 - MAG_BITS;
   localparam int          PW   = MAG_BITS + 32;
   localparam logic [31:0] GAIN = p2r_gain_comp(STAGES);

   logic              s1_valid_ff;
   logic [PW-1:0]     s1_prod_ff;
   logic [P2R_ZW-1:0] s1_z_ff;
   logic              s1_fold_ff;
   logic [P2R_ZW-1:0] z_raw;
   logic [59:0]       x_mag;
   p2r_vec_type       vec_in;
   p2r_vec_type       vec_ff;

   assign z_raw = {in_phase, 16'h0000};

   // stage 1: gain multiply and quadrant fold of the angle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff <= PW'(in_mag) * PW'(GAIN);
         s1_fold_ff <= z_raw[31] ^ z_raw[30];
         s1_z_ff    <= {z_raw[31] ^ (z_raw[31] ^ z_raw[30]), z_raw[30:0]};
      end
   end

   // bring the product from Q32 to the datapath fraction
   generate
      if (FRAC >= 32) begin : g_shl
         assign x_mag = 60'(s1_prod_ff) << (FRAC - 32);
      end else begin : g_shr
         assign x_mag = 60'(s1_prod_ff >> (32 - FRAC));
      end
   endgenerate

   // stage 2: start vector, negated when the angle was folded
   always_comb begin
      vec_in.valid = s1_valid_ff;
      vec_in.x     = s1_fold_ff ? -$signed({2'b00, x_mag}) : $signed({2'b00, x_mag});
      vec_in.y     = '0;
      vec_in.z     = s1_z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff.valid <= 1'b0;
      end else if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign out_vec = vec_ff;

endmodule

/* hw/rtl/p2r_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2r_cell
// one rotation-mode micro-rotation by atan(2^-IDX), registered
// ----------------------------------------------------------------------------
module p2r_cell
   import p2r_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  p2r_vec_type in_vec,
   output p2r_vec_type out_vec
);

   localparam logic [P2R_ZW-1:0] ANGLE = P2R_ATAN[IDX % 32];

   logic signed [P2R_DW-1:0] xs;
   logic signed [P2R_DW-1:0] ys;
   p2r_vec_type              vec_in;
   p2r_vec_type              vec_ff;

   // rotate forward on a non-negative residual angle, backward otherwise
   always_comb begin
      xs           = in_vec.x >>> IDX;
      ys           = in_vec.y >>> IDX;
      vec_in.valid = in_vec.valid;
      if (!in_vec.z[P2R_ZW-1]) begin
         vec_in.x = in_vec.x - ys;
         vec_in.y = in_vec.y + xs;
         vec_in.z = in_vec.z - ANGLE;
      end else begin
         vec_in.x = in_vec.x + ys;
         vec_in.y = in_vec.y - xs;
         vec_in.z = in_vec.z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff.valid <= 1'b0;
      end else if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign out_vec = vec_ff;

endmodule

/* hw/rtl/p2r_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2r_round
// rounds both coordinates to integers (half up), saturates them to
// +-(2^MAG_BITS - 1) and holds the result beat in the output register
// ----------------------------------------------------------------------------
module p2r_round
   import p2r_pkg::*;
#(
   parameter int MAG_BITS = P2R_MAG_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  p2r_vec_type                in_vec,
   output logic                       out_valid,
   output logic signed [MAG_BITS:0]   out_real,
   output logic signed [MAG_BITS:0]   out_imag
);

   localparam int FRAC = 60 - MAG_BITS;
   localparam int RW   = P2R_DW - FRAC;

   logic                      valid_ff;
   logic signed [MAG_BITS:0]  real_ff;
   logic signed [MAG_BITS:0]  imag_ff;

   function automatic logic signed [MAG_BITS:0] finish(input logic signed [P2R_DW-1:0] v);
      logic signed [P2R_DW-1:0] sum;
      logic signed [RW-1:0]     r;
      logic signed [RW-1:0]     lim;
      sum = v + (P2R_DW'(1) << (FRAC - 1));
      r   = sum[P2R_DW-1:FRAC];
      lim = RW'((RW'(1) << MAG_BITS) - RW'(1));
      if (r > lim) begin
         r = lim;
      end else if (r < -lim) begin
         r = -lim;
      end
      return r[MAG_BITS:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_vec.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         real_ff <= finish(in_vec.x);
         imag_ff <= finish(in_vec.y);
      end
   end

   assign out_valid = valid_ff;
   assign out_real  = real_ff;
   assign out_imag  = imag_ff;

endmodule

/* hw/rtl/polar_to_rectangular_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_to_rectangular_core
// pipelined CORDIC rotator: (magnitude, phase) in, gain-compensated
// (magnitude*cos, magnitude*sin) out, rounded and saturated
// ----------------------------------------------------------------------------
//  channel  direction  tdata fields, low bit first
//  req_     in         magnitude [MAG_BITS], phase [16], zero pad to bytes
//  rsp_     out        real_part [MAG_BITS+1], imag_part [MAG_BITS+1], zero pad
//
//  one beat accepted per cycle while the skid is empty; a beat passes, in order,
//  multiply and fold, start vector, one cell per micro-rotation, output register
//  the chain advances as one while the output register is empty or taken
//  on a stall one more beat lands in the input skid register, req_tready is
//  the registered inverse of its flag
//  synchronous reset clears the valid flags only; no clearing pass
// ----------------------------------------------------------------------------
module polar_to_rectangular_core
   import p2r_pkg::*;
#(
   parameter int MAG_BITS = P2R_MAG_BITS,
   parameter int STAGES   = P2R_STAGES,
   parameter int REQ_W    = ((MAG_BITS + 16 + 7) / 8) * 8,
   parameter int RSP_W    = ((2 * (MAG_BITS + 1) + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // magnitude, phase
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // real_part, imag_part
);

   localparam int NCELL = (STAGES > 32) ? 32 : STAGES;
   localparam int PAD   = RSP_W - 2 * (MAG_BITS + 1);

   logic                      en;
   logic                      req_fire;
   logic                      skid_valid_ff;
   logic                      skid_valid_in;
   logic [MAG_BITS-1:0]       skid_mag_ff;
   logic [15:0]               skid_phase_ff;
   logic                      ent_valid;
   logic [MAG_BITS-1:0]       ent_mag;
   logic [15:0]               ent_phase;
   logic signed [MAG_BITS:0]  res_real;
   logic signed [MAG_BITS:0]  res_imag;
   p2r_vec_type               chain [NCELL+1];

   // whole chain moves unless the output beat is held
   assign en       = !rsp_tvalid || rsp_tready;
   assign req_fire = req_tvalid && req_tready;

   // input skid register
   assign req_tready    = !skid_valid_ff;
   assign skid_valid_in = en ? 1'b0 : (skid_valid_ff || req_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && req_fire) begin
         skid_mag_ff   <= req_tdata[MAG_BITS-1:0];
         skid_phase_ff <= req_tdata[MAG_BITS+15:MAG_BITS];
      end
   end

   // chain entry: held beat first, else the live one
   assign ent_valid = skid_valid_ff || req_fire;
   assign ent_mag   = skid_valid_ff ? skid_mag_ff : req_tdata[MAG_BITS-1:0];
   assign ent_phase = skid_valid_ff ? skid_phase_ff : req_tdata[MAG_BITS+15:MAG_BITS];

   p2r_prescale #(
      .MAG_BITS (MAG_BITS),
      .STAGES   (STAGES)
   ) u_prescale (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (ent_valid),
      .in_mag   (ent_mag),
      .in_phase (ent_phase),
      .out_vec  (chain[0])
   );

   // row of micro-rotation cells
   generate
      for (genvar i = 0; i < NCELL; i++) begin : g_cell
         p2r_cell #(
            .IDX (i)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .en      (en),
            .in_vec  (chain[i]),
            .out_vec (chain[i+1])
         );
      end
   endgenerate

   p2r_round #(
      .MAG_BITS (MAG_BITS)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vec    (chain[NCELL]),
      .out_valid (rsp_tvalid),
      .out_real  (res_real),
      .out_imag  (res_imag)
   );

   // result packing
   generate
      if (PAD > 0) begin : g_pad
         assign rsp_tdata = {{PAD{1'b0}}, res_imag, res_real};
      end else begin : g_nopad
         assign rsp_tdata = {res_imag, res_real};
      end
   endgenerate

   // skid only fills while the output beat is held
   a_skid_needs_stall: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_tvalid)
      else $error("skid register full without a held output beat");

   // folded start angle lies in [-pi/2, pi/2)
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      chain[0].valid |-> (chain[0].z[P2R_ZW-1] == chain[0].z[P2R_ZW-2]))
      else $error("start angle outside the right half plane");

   // residual angle converges toward zero at the end of the row
   a_residual: assert property (@(posedge clock) disable iff (reset)
      chain[NCELL].valid |->
         (chain[NCELL].z[P2R_ZW-1:P2R_ZW-8] == 8'h00) ||
         (chain[NCELL].z[P2R_ZW-1:P2R_ZW-8] == 8'hFF))
      else $error("residual angle did not converge");

   // saturation never yields the most negative code
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (res_real != {1'b1, {MAG_BITS{1'b0}}}) &&
                     (res_imag != {1'b1, {MAG_BITS{1'b0}}}))
      else $error("output beyond the saturation limit");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for polar_to_rectangular_core: polar beats go in on
// req_ and each rsp_ beat is compared field by field with the oldest pending
// prediction from a bit-exact fixed-point cordic model kept in the bench;
// a directed corner table comes first, then random beats that favor
// quadrant edges and extreme radii, with both sides idling at random
// ----------------------------------------------------------------------------
module tb;
   import p2r_pkg::*;

   localparam int MAG_BITS  = P2R_MAG_BITS;
   localparam int STAGES    = P2R_STAGES;
   localparam int REQ_W     = ((MAG_BITS + 16 + 7) / 8) * 8;
   localparam int RSP_W     = ((2 * (MAG_BITS + 1) + 7) / 8) * 8;
   localparam int FRAC      = 60 - MAG_BITS;
   localparam int ROT_CELLS = (STAGES > 32) ? 32 : STAGES;
   localparam int RAND_BEATS = 400;
   localparam int N_CORNERS  = 20;
   localparam logic signed [63:0] SAT_LIM = (64'sd1 <<< MAG_BITS) - 64'sd1;

   // arctangent of 2^-i, full turn = 2^32, truncated
   localparam logic [31:0] ATAN_TURN [32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
   };

   typedef struct packed {
      logic [MAG_BITS:0] re;
      logic [MAG_BITS:0] im;
   } rect_pair_type;

   // corner row: radius, angle, whether the answer is typed in, typed answer
   typedef struct packed {
      logic [MAG_BITS-1:0] mag;
      logic [15:0]         ph;
      logic                known;
      logic [MAG_BITS:0]   re;
      logic [MAG_BITS:0]   im;
   } corner_row_type;

   localparam corner_row_type CORNER_ROWS [N_CORNERS] = '{
      // zero radius gives zero whatever the angle, folded or not
      '{16'h0000, 16'h0000, 1'b1, 17'd0, 17'd0},
      '{16'h0000, 16'h8000, 1'b1, 17'd0, 17'd0},
      '{16'h0000, 16'h7FFF, 1'b1, 17'd0, 17'd0},
      // full radius on the axes, quadrant edges and diagonals
      '{16'hFFFF, 16'h0000, 1'b0, 17'd0, 17'd0},
      '{16'hFFFF, 16'h4000, 1'b0, 17'd0, 17'd0},
      '{16'hFFFF, 16'hC000, 1'b0, 17'd0, 17'd0},
      '{16'hFFFF, 16'h8000, 1'b0, 17'd0, 17'd0},
      '{16'hFFFF, 16'h7FFF, 1'b0, 17'd0, 17'd0},
      '{16'hFFFF, 16'h3FFF, 1'b0, 17'd0, 17'd0},
      '{16'hFFFF, 16'hBFFF, 1'b0, 17'd0, 17'd0},
      '{16'hFFFF, 16'h2000, 1'b0, 17'd0, 17'd0},
      '{16'hFFFF, 16'hE000, 1'b0, 17'd0, 17'd0},
      '{16'hFFFF, 16'hFFFF, 1'b0, 17'd0, 17'd0},
      // unit radius, rounding dominates
      '{16'h0001, 16'h0000, 1'b0, 17'd0, 17'd0},
      '{16'h0001, 16'h4000, 1'b0, 17'd0, 17'd0},
      '{16'h0001, 16'h8000, 1'b0, 17'd0, 17'd0},
      // alternating bit patterns and mid values
      '{16'h8000, 16'h6000, 1'b0, 17'd0, 17'd0},
      '{16'hAAAA, 16'h5555, 1'b0, 17'd0, 17'd0},
      '{16'h5555, 16'hAAAA, 1'b0, 17'd0, 17'd0},
      '{16'h8000, 16'h0001, 1'b0, 17'd0, 17'd0}
   };

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;    // magnitude, phase
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;    // real_part, imag_part

   rect_pair_type pending_rect[$];
   logic [63:0]   gain_q32;
   bit            quiet;
   int            beats_sent;
   int            results_seen;
   int            mismatches;
   int            sink_hold;

   polar_to_rectangular_core #(
      .MAG_BITS(MAG_BITS),
      .STAGES  (STAGES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // gain compensation 2^63 / sqrt(prod(1 + 4^-i)), unsigned Q32
   function automatic logic [63:0] gain_comp_q32();
      logic [63:0] p;
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] bitv;
      p = 64'd1 << 62;
      for (int i = 0; i < ROT_CELLS; i++) begin
         if (2 * i < 64) begin
            p = p + (p >> (2 * i));
         end
      end
      rest = p;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > rest) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rest >= root + bitv) begin
            rest = rest - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return (64'd1 << 63) / root;
   endfunction

   // round half up to an integer and clamp to the symmetric output range
   function automatic logic [MAG_BITS:0] round_clamp(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (r > SAT_LIM) r = SAT_LIM;
      if (r < -SAT_LIM) r = -SAT_LIM;
      return r[MAG_BITS:0];
   endfunction

   // rotation-mode cordic from (radius, 0) through the binary angle
   function automatic rect_pair_type polar_to_rect(input logic [MAG_BITS-1:0] mag,
                                                   input logic [15:0] ph);
      logic [63:0]        prod;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] xn;
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      logic [31:0]        z;
      rect_pair_type      res;
      prod = 64'(mag) * gain_q32;
      if (FRAC >= 32) x = prod << (FRAC - 32);
      else x = prod >> (32 - FRAC);
      y = '0;
      z = {ph, 16'h0000};
      // fold the left half plane onto the right one
      if (z[31:30] == 2'b01 || z[31:30] == 2'b10) begin
         x = -x;
         z = z + 32'h8000_0000;
      end
      for (int i = 0; i < ROT_CELLS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (!z[31]) begin
            xn = x - ys;
            y  = y + xs;
            z  = z - ATAN_TURN[i];
         end else begin
            xn = x + ys;
            y  = y - xs;
            z  = z + ATAN_TURN[i];
         end
         x = xn;
      end
      res.re = round_clamp(x);
      res.im = round_clamp(y);
      return res;
   endfunction

   // idle run length: mostly short, now and then long
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // offer one beat, hold it until taken, then queue its answer
   task automatic send_polar(input logic [MAG_BITS-1:0] mag, input logic [15:0] ph,
                             input rect_pair_type want);
      int gap;
      gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({ph, mag});
      do @(posedge clock); while (!req_tready);
      pending_rect.push_back(want);
      beats_sent++;
   endtask

   // random radius: full range, near the top, small, all zeros or all ones, or a single set bit
   function automatic logic [MAG_BITS-1:0] pick_radius();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return MAG_BITS'($urandom);
      if (sel < 6) return {MAG_BITS{1'b1}} - MAG_BITS'($urandom_range(0, 255));
      if (sel < 8) return MAG_BITS'($urandom_range(0, 255));
      if (sel < 9) return ($urandom_range(0, 1) == 0) ? '0 : {MAG_BITS{1'b1}};
      return MAG_BITS'(1) << $urandom_range(0, MAG_BITS - 1);
   endfunction

   // random angle: uniform, or close to a quadrant edge
   function automatic logic [15:0] pick_angle();
      if ($urandom_range(0, 9) < 6) return 16'($urandom);
      return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 8) - 4);
   endfunction

   // response side: check every taken beat, stall at random
   initial begin
      rect_pair_type     want;
      logic [MAG_BITS:0] got_re;
      logic [MAG_BITS:0] got_im;
      rsp_tready <= 1'b0;
      sink_hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            results_seen++;
            got_re = rsp_tdata[MAG_BITS:0];
            got_im = rsp_tdata[2*MAG_BITS+1:MAG_BITS+1];
            if (pending_rect.size() == 0) begin
               $error("rsp beat with nothing pending: real_part %0d imag_part %0d",
                      $signed(got_re), $signed(got_im));
               mismatches++;
            end else begin
               want = pending_rect.pop_front();
               if (got_re !== want.re) begin
                  $error("real_part: expected %0d, got %0d",
                         $signed(want.re), $signed(got_re));
                  mismatches++;
               end
               if (got_im !== want.im) begin
                  $error("imag_part: expected %0d, got %0d",
                         $signed(want.im), $signed(got_im));
                  mismatches++;
               end
               if (rsp_tdata[RSP_W-1:2*MAG_BITS+2] !== '0) begin
                  $error("pad: expected 0, got %0h", rsp_tdata[RSP_W-1:2*MAG_BITS+2]);
                  mismatches++;
               end
            end
         end
         if (quiet) begin
            rsp_tready <= 1'b1;
            sink_hold = 0;
         end else if (sink_hold != 0) begin
            sink_hold--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            sink_hold = idle_length() - 1;
         end else begin
            rsp_tready <= 1'b1;
            sink_hold = $urandom_range(0, 7);
         end
      end
   end

   // main sequence: reset, corner table, random beats, drain
   initial begin
      corner_row_type      row;
      rect_pair_type       want;
      logic [MAG_BITS-1:0] mag;
      logic [15:0]         ph;
      int                  drain_wait;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      quiet = 1'b0;
      beats_sent = 0;
      results_seen = 0;
      mismatches = 0;
      gain_q32 = gain_comp_q32();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      for (int k = 0; k < N_CORNERS; k++) begin
         row = CORNER_ROWS[k];
         if (row.known) begin
            want.re = row.re;
            want.im = row.im;
         end else begin
            want = polar_to_rect(row.mag, row.ph);
         end
         send_polar(row.mag, row.ph, want);
      end

      // random beats, with one back-to-back stretch in the middle
      for (int k = 0; k < RAND_BEATS; k++) begin
         quiet = (k >= 150 && k < 230);
         mag = pick_radius();
         ph  = pick_angle();
         send_polar(mag, ph, polar_to_rect(mag, ph));
      end
      req_tvalid <= 1'b0;
      quiet = 1'b0;

      while (pending_rect.size() != 0) @(posedge clock);
      drain_wait = STAGES + 8;
      repeat (drain_wait) @(posedge clock);

      $display("tb: %0d beats sent (%0d corner, %0d random), %0d results checked",
               beats_sent, N_CORNERS, RAND_BEATS, results_seen);
      $display("tb: %0d mismatches, radii 0..max, all quadrants and fold edges",
               mismatches);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/p2r_pkg.sv
hw/rtl/p2r_prescale.sv
hw/rtl/p2r_cell.sv
hw/rtl/p2r_round.sv
hw/rtl/polar_to_rectangular_core.sv
verif/tb.sv
